[rtl/mux_adc_scan_collector_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the mux ADC scan collector
// Shared shorthand for clocked implication checks with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef MUX_ADC_SCAN_COLLECTOR_MACROS_SVH
`define MUX_ADC_SCAN_COLLECTOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MASC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MASC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/masc_pkg.sv]
// ----------------------------------------------------------------------------
// masc_pkg
// Types and constants of the mux ADC scan collector.
// ----------------------------------------------------------------------------
package masc_pkg;

  localparam int CHANNELS        = 8;
  localparam int CH_W            = $clog2(CHANNELS);
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int ADC_W           = 12;
  localparam int RAW_W           = 12;
  localparam int CNT_W           = 32;
  localparam logic [CHANNELS-1:0] ALL_VALID = '1;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             conversion_ok;
    logic [ADC_W-1:0] adc_value;
  } conv_t;

  typedef struct packed {
    logic [CH_W-1:0]     mux_select;
    logic                scan_data;
    logic [CH_W-1:0]     channel_index;
    logic [RAW_W-1:0]    chan_sample;
    logic [RAW_W-1:0]    scan_min;
    logic [RAW_W-1:0]    scan_max;
    logic [CNT_W-1:0]    scan_number;
    logic [CNT_W-1:0]    sample_total;
    logic [CNT_W-1:0]    timeout_total;
    logic [CNT_W-1:0]    incomplete_total;
    logic [CHANNELS-1:0] finished_scan_mask;
    logic                last_of_run;
  } res_t;

endpackage

[rtl/mux_adc_scan_collector.sv]
// A mid-scan conversion is absorbed and yields no result.
// An incomplete scan puts its status result on res in the cycle after acceptance.
// A complete scan reads the raw store once per channel: 8 results, one per
// free res cycle after a registered read; input resumes once the last
// entry has been loaded into res, so a stalled res holds the input longer.
// Reset (rst, synchronous) clears channel, masks, counters and the handshake.
// ----------------------------------------------------------------------------
// mux_adc_scan_collector
// Collects one conversion per mux channel into a raw store and, at the end of
// every scan, emits either the full scan (one result per channel) or a status.
// ----------------------------------------------------------------------------
module mux_adc_scan_collector #(
  parameter int SAMPLE_BITS = masc_pkg::SAMPLE_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            conv_valid,
  output logic            conv_stall,
  input  masc_pkg::conv_t conv,
  output logic            res_valid,
  input  logic            res_stall,
  output masc_pkg::res_t  res
);

  localparam int CH_W  = masc_pkg::CH_W;
  localparam int CNT_W = masc_pkg::CNT_W;
  localparam int RAW_W = masc_pkg::RAW_W;
  localparam int ADC_W = masc_pkg::ADC_W;
  localparam int CHN   = masc_pkg::CHANNELS;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHN - 1);

  // Raw store: one sample per channel, one write and one registered read port.
  // Entries are read only after a scan in which every channel was written,
  // so the reset contents are never observed and need no clearing pass.
  logic [SAMPLE_BITS-1:0] raw_mem [CHN];
  logic [SAMPLE_BITS-1:0] rd_data;

  masc_pkg::state_t state, state_next;

  // Scan state and counters.
  logic [CH_W-1:0]        cur_ch;
  logic [CHN-1:0]         valid_mask;
  logic [CHN-1:0]         finished_mask;
  logic [SAMPLE_BITS-1:0] scan_lo;
  logic [SAMPLE_BITS-1:0] scan_hi;
  logic [CNT_W-1:0]       sample_cnt;
  logic [CNT_W-1:0]       timeout_cnt;
  logic [CNT_W-1:0]       incomplete_cnt;
  logic [CNT_W-1:0]       scan_cnt;
  logic [CH_W-1:0]        emit_idx;

  // Next values for one accepted transaction.
  logic [CH_W-1:0]        cur_ch_next;
  logic [CHN-1:0]         valid_mask_next;
  logic [SAMPLE_BITS-1:0] scan_lo_next;
  logic [SAMPLE_BITS-1:0] scan_hi_next;
  logic [CNT_W-1:0]       sample_cnt_next;
  logic [CNT_W-1:0]       timeout_cnt_next;
  logic [CNT_W-1:0]       incomplete_cnt_next;
  logic [CNT_W-1:0]       scan_cnt_next;

  logic                   conv_accept;
  logic                   scan_end;
  logic                   scan_complete;
  logic                   load_status;
  logic                   load_emit;
  logic                   rd_en;
  logic [CH_W-1:0]        rd_addr;

  logic [SAMPLE_BITS-1:0]       sample;
  logic [SAMPLE_BITS+ADC_W-1:0] sample_ext;
  logic [SAMPLE_BITS+RAW_W-1:0] raw_ext;
  logic [SAMPLE_BITS+RAW_W-1:0] lo_ext;
  logic [SAMPLE_BITS+RAW_W-1:0] hi_ext;

  // Fit the converter word to the store width (drop upper bits or zero-fill),
  // and the stored words to the result field width.
  assign sample_ext = {{SAMPLE_BITS{1'b0}}, conv.adc_value};
  assign sample     = sample_ext[SAMPLE_BITS-1:0];
  assign raw_ext    = {{RAW_W{1'b0}}, rd_data};
  assign lo_ext     = {{RAW_W{1'b0}}, scan_lo};
  assign hi_ext     = {{RAW_W{1'b0}}, scan_hi};

  assign conv_accept = conv_valid && !conv_stall;

  // Per-transaction update. Each channel is written at most once per scan,
  // so a running min/max over this scan's writes equals the min/max over
  // the store once all channels are valid. An empty mask restarts it.
  always_comb begin
    cur_ch_next      = cur_ch + CH_W'(1);
    valid_mask_next  = valid_mask;
    scan_lo_next     = scan_lo;
    scan_hi_next     = scan_hi;
    sample_cnt_next  = sample_cnt;
    timeout_cnt_next = timeout_cnt;
    if (conv.conversion_ok) begin
      valid_mask_next = valid_mask | (CHN'(1) << cur_ch);
      sample_cnt_next = sample_cnt + CNT_W'(1);
      if (valid_mask == '0) begin
        scan_lo_next = sample;
        scan_hi_next = sample;
      end else begin
        scan_lo_next = (sample < scan_lo) ? sample : scan_lo;
        scan_hi_next = (sample > scan_hi) ? sample : scan_hi;
      end
    end else begin
      timeout_cnt_next = timeout_cnt + CNT_W'(1);
    end
    scan_end            = (cur_ch == LAST_CH);
    scan_complete       = scan_end && (valid_mask_next == masc_pkg::ALL_VALID);
    scan_cnt_next       = scan_cnt + CNT_W'(scan_complete);
    incomplete_cnt_next = incomplete_cnt + CNT_W'(scan_end && !scan_complete);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      masc_pkg::ST_IDLE: begin
        if (conv_accept && scan_complete) begin
          state_next = masc_pkg::ST_EMIT;
        end
      end
      masc_pkg::ST_EMIT: begin
        if (load_emit && emit_idx == LAST_CH) begin
          state_next = masc_pkg::ST_IDLE;
        end
      end
      default: state_next = masc_pkg::ST_IDLE;
    endcase
  end

  // Control outputs. Hold the input while emitting a scan, and at the end of
  // a scan until the result register can take a status transaction.
  // The first read (entry 0) goes with the last channel's write, which lands
  // before that channel is read, so no forwarding path is needed.
  always_comb begin
    conv_stall  = 1'b1;
    load_status = 1'b0;
    load_emit   = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    case (state)
      masc_pkg::ST_IDLE: begin
        conv_stall  = (cur_ch == LAST_CH) && res_valid && res_stall;
        load_status = conv_accept && scan_end && !scan_complete;
        rd_en       = conv_accept && scan_complete;
        rd_addr     = '0;
      end
      masc_pkg::ST_EMIT: begin
        load_emit = !res_valid || !res_stall;
        rd_en     = load_emit && (emit_idx != LAST_CH);
        rd_addr   = emit_idx + CH_W'(1);
      end
      default: begin
        conv_stall = 1'b1;
      end
    endcase
  end

  // Raw store write and registered read.
  always_ff @(posedge clk) begin
    if (conv_accept && conv.conversion_ok) begin
      raw_mem[cur_ch] <= sample;
    end
    if (rd_en) begin
      rd_data <= raw_mem[rd_addr];
    end
  end

  // Scan state, counters and the emit pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= masc_pkg::ST_IDLE;
      cur_ch         <= '0;
      valid_mask     <= '0;
      finished_mask  <= '0;
      sample_cnt     <= '0;
      timeout_cnt    <= '0;
      incomplete_cnt <= '0;
      scan_cnt       <= '0;
      emit_idx       <= '0;
    end else begin
      state <= state_next;
      if (conv_accept) begin
        cur_ch         <= cur_ch_next;
        sample_cnt     <= sample_cnt_next;
        timeout_cnt    <= timeout_cnt_next;
        incomplete_cnt <= incomplete_cnt_next;
        scan_cnt       <= scan_cnt_next;
        emit_idx       <= '0;
        if (scan_end) begin
          finished_mask <= valid_mask_next;
          valid_mask    <= '0;
        end else begin
          valid_mask <= valid_mask_next;
        end
      end else if (load_emit) begin
        // Advance to the entry being fetched for the next result.
        emit_idx <= emit_idx + CH_W'(1);
      end
    end
  end

  // Running extremes are payload; their validity follows valid_mask.
  always_ff @(posedge clk) begin
    if (conv_accept) begin
      scan_lo <= scan_lo_next;
      scan_hi <= scan_hi_next;
    end
  end

  // Result register: one status transaction, or one scan entry per cycle while res is not stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_status || load_emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_status) begin
      res.mux_select         <= cur_ch_next;
      res.scan_data          <= 1'b0;
      res.channel_index      <= '0;
      res.chan_sample        <= '0;
      res.scan_min           <= '0;
      res.scan_max           <= '0;
      res.scan_number        <= scan_cnt_next;
      res.sample_total       <= sample_cnt_next;
      res.timeout_total      <= timeout_cnt_next;
      res.incomplete_total   <= incomplete_cnt_next;
      res.finished_scan_mask <= valid_mask_next;
      res.last_of_run        <= 1'b1;
    end else if (load_emit) begin
      // Counters and masks already hold the values after the last channel.
      res.mux_select         <= cur_ch;
      res.scan_data          <= 1'b1;
      res.channel_index      <= emit_idx;
      res.chan_sample        <= raw_ext[RAW_W-1:0];
      res.scan_min           <= lo_ext[RAW_W-1:0];
      res.scan_max           <= hi_ext[RAW_W-1:0];
      res.scan_number        <= scan_cnt;
      res.sample_total       <= sample_cnt;
      res.timeout_total      <= timeout_cnt;
      res.incomplete_total   <= incomplete_cnt;
      res.finished_scan_mask <= finished_mask;
      res.last_of_run        <= (emit_idx == LAST_CH);
    end
  end

  // Terms for the checks below.
  logic emit_phase;
  logic scan_clear;
  logic res_data;
  logic res_status;
  logic last_ok;
  logic full_mask;
  logic status_ok;
  logic emit_top;

  assign emit_phase = (state == masc_pkg::ST_EMIT);
  assign scan_clear = (cur_ch == '0) && (valid_mask == '0);
  assign res_data   = res_valid && res.scan_data;
  assign res_status = res_valid && !res.scan_data;
  assign last_ok    = (res.last_of_run == (res.channel_index == LAST_CH));
  assign full_mask  = (res.finished_scan_mask == masc_pkg::ALL_VALID);
  assign status_ok  = res.last_of_run && (res.channel_index == '0) && (res.chan_sample == '0);
  assign emit_top   = load_emit && (emit_idx == LAST_CH);

`include "mux_adc_scan_collector_macros.svh"

  `MASC_ASSERT_SAME(a_emit_at_wrap, clk, rst, emit_phase, scan_clear, "emit in mid-scan")
  `MASC_ASSERT_SAME(a_last_is_top, clk, rst, res_data, last_ok, "last_of_run off the top entry")
  `MASC_ASSERT_SAME(a_data_full, clk, rst, res_data, full_mask, "scan data missing a channel")
  `MASC_ASSERT_SAME(a_status_zero, clk, rst, res_status, status_ok, "status with channel data")
  `MASC_ASSERT_NEXT(a_emit_done, clk, rst, emit_top, !emit_phase, "emit did not end")

endmodule
